@@ rtl/rcrs_pkg.sv @@
// Package with the shared types and constants of the row and column reference shift unit.
package rcrs_pkg;

  localparam int ROW_W  = 20;
  localparam int COL_W  = 14;
  localparam int REG_W  = 21;
  localparam int CALC_W = 22;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [CALC_W-1:0] ROW_LIMIT = CALC_W'(1048576);
  localparam logic [CALC_W-1:0] COL_LIMIT = CALC_W'(16384);

  localparam logic AXIS_ROW    = 1'b0;
  localparam logic AXIS_COL    = 1'b1;
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DELETE = 1'b1;
  localparam logic OP_SINGLE   = 1'b0;
  localparam logic OP_RANGE    = 1'b1;

  localparam logic [1:0] SCOPE_LOCAL  = 2'd0;
  localparam logic [1:0] SCOPE_TARGET = 2'd1;

  localparam logic [2:0] REG_AXIS  = 3'd0;
  localparam logic [2:0] REG_KIND  = 3'd1;
  localparam logic [2:0] REG_INDEX = 3'd2;
  localparam logic [2:0] REG_COUNT = 3'd3;
  localparam logic [2:0] REG_LOCAL = 3'd4;

  typedef struct packed {
    logic             axis;
    logic             kind;
    logic [REG_W-1:0] index;
    logic [REG_W-1:0] count;
    logic             local_is_target;
  } cfg_t;

  typedef struct packed {
    logic             operation;
    logic [1:0]       first_scope;
    logic [1:0]       second_scope;
    logic             same_sheet;
    logic [ROW_W-1:0] first_row;
    logic [COL_W-1:0] first_col;
    logic             first_whole_row;
    logic             first_whole_col;
    logic [ROW_W-1:0] second_row;
    logic [COL_W-1:0] second_col;
    logic             second_whole_row;
    logic             second_whole_col;
  } item_t;

  typedef struct packed {
    logic             ref_valid;
    logic [ROW_W-1:0] out_first_row;
    logic [COL_W-1:0] out_first_col;
    logic [ROW_W-1:0] out_second_row;
    logic [COL_W-1:0] out_second_col;
  } result_t;

endpackage

@@ rtl/rcrs_cfg.sv @@
// Configuration register file with its APB-style access port.
module rcrs_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rcrs_pkg::ADDR_W-1:0]  paddr,
  input  logic [rcrs_pkg::DATA_W-1:0]  pwdata,
  output logic [rcrs_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output rcrs_pkg::cfg_t               cfg
);
  import rcrs_pkg::*;

  logic       wr_en;
  logic [2:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_AXIS:  cfg.axis            <= pwdata[0];
        REG_KIND:  cfg.kind            <= pwdata[0];
        REG_INDEX: cfg.index           <= pwdata[REG_W-1:0];
        REG_COUNT: cfg.count           <= pwdata[REG_W-1:0];
        REG_LOCAL: cfg.local_is_target <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_AXIS:  prdata = DATA_W'(cfg.axis);
      REG_KIND:  prdata = DATA_W'(cfg.kind);
      REG_INDEX: prdata = DATA_W'(cfg.index);
      REG_COUNT: prdata = DATA_W'(cfg.count);
      REG_LOCAL: prdata = DATA_W'(cfg.local_is_target);
      default:   prdata = '0;
    endcase
  end

endmodule

@@ rtl/rcrs_map.sv @@
// Combinational remap of one reference or range for the configured edit.
module rcrs_map (
  input  rcrs_pkg::cfg_t    cfg,
  input  rcrs_pkg::item_t   item,
  output rcrs_pkg::result_t result
);
  import rcrs_pkg::*;

  typedef struct packed {
    logic              ok;
    logic [CALC_W-1:0] val;
  } coord_res_t;

  typedef struct packed {
    logic             ok;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } ep_res_t;

  typedef struct packed {
    logic              ok;
    logic [CALC_W-1:0] a;
    logic [CALC_W-1:0] b;
  } pair_res_t;

  function automatic logic in_scope(input logic [1:0] cls, input logic lit);
    logic r;
    r = (cls == SCOPE_LOCAL) ? lit : (cls == SCOPE_TARGET);
    return r;
  endfunction

  function automatic coord_res_t map_coord(input logic [CALC_W-1:0] c,
                                           input logic [CALC_W-1:0] bound,
                                           input cfg_t cf);
    coord_res_t        r;
    logic [CALC_W-1:0] idx;
    logic [CALC_W-1:0] cnt;
    logic [CALC_W-1:0] s;
    idx   = CALC_W'(cf.index);
    cnt   = CALC_W'(cf.count);
    s     = c + cnt;
    r.ok  = 1'b1;
    r.val = c;
    if (c >= idx) begin
      if (cf.kind == KIND_INSERT) begin
        r.ok  = s < bound;
        r.val = s;
      end else begin
        r.ok  = c >= (idx + cnt);
        r.val = c - cnt;
      end
    end
    return r;
  endfunction

  function automatic ep_res_t map_endpoint(input logic [1:0] cls,
                                           input logic [ROW_W-1:0] row,
                                           input logic [COL_W-1:0] col,
                                           input logic wr, input logic wc,
                                           input cfg_t cf);
    ep_res_t    r;
    coord_res_t m;
    r.ok  = 1'b1;
    r.row = row;
    r.col = col;
    if (in_scope(cls, cf.local_is_target)) begin
      if (cf.axis == AXIS_ROW) begin
        if (!wc) begin
          m     = map_coord(CALC_W'(row), ROW_LIMIT, cf);
          r.ok  = m.ok;
          r.row = m.val[ROW_W-1:0];
        end
      end else if (!wr) begin
        m     = map_coord(CALC_W'(col), COL_LIMIT, cf);
        r.ok  = m.ok;
        r.col = m.val[COL_W-1:0];
      end
    end
    return r;
  endfunction

  function automatic pair_res_t clamp_interval(input logic [CALC_W-1:0] f,
                                               input logic [CALC_W-1:0] l,
                                               input logic [CALC_W-1:0] bound,
                                               input cfg_t cf);
    pair_res_t         r;
    coord_res_t        m1;
    coord_res_t        m2;
    logic [CALC_W-1:0] lo;
    logic [CALC_W-1:0] hi;
    logic [CALC_W-1:0] dbeg;
    logic [CALC_W-1:0] dend;
    logic [CALC_W-1:0] slo;
    logic [CALC_W-1:0] shi;
    logic              pre;
    logic              suf;
    lo   = (f < l) ? f : l;
    hi   = (f < l) ? l : f;
    dbeg = CALC_W'(cf.index);
    dend = dbeg + CALC_W'(cf.count);
    pre  = lo < dbeg;
    suf  = hi >= dend;
    slo  = pre ? lo : dbeg;
    shi  = suf ? (hi - CALC_W'(cf.count)) : (dbeg - CALC_W'(1));
    m1   = map_coord(f, bound, cf);
    m2   = map_coord(l, bound, cf);
    if (cf.count == '0 || hi < dbeg || lo >= dend) begin
      r.ok = m1.ok && m2.ok;
      r.a  = m1.val;
      r.b  = m2.val;
    end else begin
      r.ok = (pre || suf) && (slo < bound) && (shi < bound) && (slo <= shi);
      r.a  = (f <= l) ? slo : shi;
      r.b  = (f <= l) ? shi : slo;
    end
    return r;
  endfunction

  ep_res_t   ep1;
  ep_res_t   ep2;
  pair_res_t row_pair;
  pair_res_t col_pair;
  logic      clamp;
  logic      ok;
  result_t   res;

  always_comb begin
    ep1      = map_endpoint(item.first_scope, item.first_row, item.first_col,
                            item.first_whole_row, item.first_whole_col, cfg);
    ep2      = map_endpoint(item.second_scope, item.second_row, item.second_col,
                            item.second_whole_row, item.second_whole_col, cfg);
    row_pair = clamp_interval(CALC_W'(item.first_row), CALC_W'(item.second_row),
                              ROW_LIMIT, cfg);
    col_pair = clamp_interval(CALC_W'(item.first_col), CALC_W'(item.second_col),
                              COL_LIMIT, cfg);
    clamp    = item.same_sheet && in_scope(item.first_scope, cfg.local_is_target)
               && (item.first_whole_row == item.second_whole_row)
               && (item.first_whole_col == item.second_whole_col)
               && (cfg.kind == KIND_DELETE)
               && !((cfg.axis == AXIS_ROW && item.first_whole_col)
                    || (cfg.axis == AXIS_COL && item.first_whole_row));

    res.ref_valid      = 1'b1;
    res.out_first_row  = ep1.row;
    res.out_first_col  = ep1.col;
    res.out_second_row = '0;
    res.out_second_col = '0;
    ok                 = ep1.ok;

    if (item.operation == OP_RANGE) begin
      if (clamp) begin
        res.out_first_row  = item.first_row;
        res.out_first_col  = item.first_col;
        res.out_second_row = item.second_row;
        res.out_second_col = item.second_col;
        if (cfg.axis == AXIS_ROW) begin
          ok                 = row_pair.ok;
          res.out_first_row  = row_pair.a[ROW_W-1:0];
          res.out_second_row = row_pair.b[ROW_W-1:0];
        end else begin
          ok                 = col_pair.ok;
          res.out_first_col  = col_pair.a[COL_W-1:0];
          res.out_second_col = col_pair.b[COL_W-1:0];
        end
      end else begin
        ok                 = ep1.ok && ep2.ok;
        res.out_second_row = ep2.row;
        res.out_second_col = ep2.col;
      end
    end

    result = ok ? res : '0;
  end

endmodule

@@ rtl/row_col_reference_shift_unit.sv @@
// Top level of the row and column reference shift unit.
//
// The unit remaps one grid reference or range per transfer for a row or
// column insert or delete described in the configuration registers.
// An item is taken on item at a clock edge where start is high and busy is
// low. Busy is always low, so a new item may be started in every cycle and
// the sustained rate is one item per cycle.
// The item is captured in an input register, remapped by a single pass of
// compare, add and subtract logic, and captured in the result register.
// The result is on result with result_valid high for exactly one cycle,
// after the item has passed the input register and the result register;
// the receiver cannot stall it. Configuration must be written through the
// APB-style port while no item is in flight; the block does not enforce
// it. Reset clears the configuration registers to zero and empties the
// pipeline; no item is lost or repeated for any pattern of starts.
module row_col_reference_shift_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  rcrs_pkg::item_t              item,
  output logic                         result_valid,
  output rcrs_pkg::result_t            result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rcrs_pkg::ADDR_W-1:0]  paddr,
  input  logic [rcrs_pkg::DATA_W-1:0]  pwdata,
  output logic [rcrs_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import rcrs_pkg::*;

  cfg_t    cfg;
  item_t   item_reg;
  logic    item_valid;
  result_t result_next;

  assign busy = 1'b0;

  rcrs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rcrs_map u_map (
    .cfg    (cfg),
    .item   (item_reg),
    .result (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      item_valid   <= start && !busy;
      result_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_reg <= item;
    end
    if (item_valid) begin
      result <= result_next;
    end
  end

  a_accept_to_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 result_valid)
    else $error("accepted item produced no result transfer");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##2 !result_valid)
    else $error("result transfer without an accepted item");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.ref_valid) |->
      (result.out_first_row == '0 && result.out_first_col == '0 &&
       result.out_second_row == '0 && result.out_second_col == '0))
    else $error("invalid reference carries nonzero coordinates");

  a_single_second_zero: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.operation == OP_SINGLE) |-> ##2
      (result.out_second_row == '0 && result.out_second_col == '0))
    else $error("single reference has a nonzero second endpoint");

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench of the row and column reference shift unit: directed table, then random phases.
module testbench;
  import rcrs_pkg::*;

  typedef logic [22:0] span_t;

  typedef struct packed {
    cfg_t    cfg;
    item_t   stim;
    logic    typed;
    result_t want;
  } directed_row_t;

  localparam logic [1:0] SCOPE_OTHER = 2'd2;
  localparam logic [1:0] SCOPE_SPARE = 2'd3;
  localparam int unsigned ROW_MASK = 32'h000F_FFFF;
  localparam int unsigned COL_MASK = 32'h0000_3FFF;
  localparam result_t INVALID_REF = '0;
  localparam int STALL_LIMIT = 1000;
  localparam int PHASES = 12;
  localparam int ITEMS_PER_PHASE = 125;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  item_t               item;
  logic                result_valid;
  result_t             result;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  logic                use_typed;
  result_t             typed_result;

  cfg_t                edit_cfg;
  result_t             expected_results[$];
  directed_row_t       directed_rows[$];
  int                  failures;
  int                  quiet_cycles;

  row_col_reference_shift_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .result_valid(result_valid),
    .result      (result),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #1 clk = ~clk;

  function automatic logic on_edited_sheet(input logic [1:0] cls);
    if (cls == SCOPE_LOCAL) return edit_cfg.local_is_target;
    return cls == SCOPE_TARGET;
  endfunction

  function automatic logic remap_coord(input span_t c, input span_t bound, output span_t res);
    span_t idx;
    span_t cnt;
    idx = span_t'(edit_cfg.index);
    cnt = span_t'(edit_cfg.count);
    res = c;
    if (c < idx) return 1'b1;
    if (edit_cfg.kind == KIND_INSERT) begin
      res = c + cnt;
      return res < bound;
    end
    res = c - cnt;
    return c >= idx + cnt;
  endfunction

  function automatic logic remap_endpoint(input logic [1:0] cls, inout span_t row,
                                          inout span_t col, input logic wrow, input logic wcol);
    if (!on_edited_sheet(cls)) return 1'b1;
    if (edit_cfg.axis == AXIS_ROW) begin
      if (wcol) return 1'b1;
      return remap_coord(row, span_t'(ROW_LIMIT), row);
    end
    if (wrow) return 1'b1;
    return remap_coord(col, span_t'(COL_LIMIT), col);
  endfunction

  function automatic logic clamp_span(input span_t first, input span_t last, input span_t bound,
                                      output span_t o1, output span_t o2);
    span_t lo;
    span_t hi;
    span_t dbeg;
    span_t dend;
    span_t slo;
    span_t shi;
    logic  pre;
    logic  suf;
    logic  ok1;
    logic  ok2;
    lo = (first < last) ? first : last;
    hi = (first < last) ? last : first;
    dbeg = span_t'(edit_cfg.index);
    dend = dbeg + span_t'(edit_cfg.count);
    o1 = first;
    o2 = last;
    if (edit_cfg.count == '0 || hi < dbeg || lo >= dend) begin
      ok1 = remap_coord(first, bound, o1);
      ok2 = remap_coord(last, bound, o2);
      return ok1 && ok2;
    end
    pre = lo < dbeg;
    suf = hi >= dend;
    if (!pre && !suf) return 1'b0;
    slo = pre ? lo : dbeg;
    shi = suf ? hi - span_t'(edit_cfg.count) : dbeg - 23'd1;
    if (slo >= bound || shi >= bound || slo > shi) return 1'b0;
    if (first <= last) begin
      o1 = slo;
      o2 = shi;
    end else begin
      o1 = shi;
      o2 = slo;
    end
    return 1'b1;
  endfunction

  function automatic result_t predict_shift(input item_t it);
    span_t   r1;
    span_t   c1;
    span_t   r2;
    span_t   c2;
    logic    ok;
    logic    ok2;
    logic    clamp;
    result_t res;
    r1 = span_t'(it.first_row);
    c1 = span_t'(it.first_col);
    r2 = span_t'(it.second_row);
    c2 = span_t'(it.second_col);
    if (it.operation == OP_SINGLE) begin
      ok = remap_endpoint(it.first_scope, r1, c1, it.first_whole_row, it.first_whole_col);
      r2 = '0;
      c2 = '0;
    end else begin
      clamp = it.same_sheet && on_edited_sheet(it.first_scope)
              && it.first_whole_row == it.second_whole_row
              && it.first_whole_col == it.second_whole_col
              && edit_cfg.kind == KIND_DELETE
              && !(edit_cfg.axis == AXIS_ROW && it.first_whole_col)
              && !(edit_cfg.axis == AXIS_COL && it.first_whole_row);
      if (clamp && edit_cfg.axis == AXIS_ROW) begin
        ok = clamp_span(r1, r2, span_t'(ROW_LIMIT), r1, r2);
      end else if (clamp) begin
        ok = clamp_span(c1, c2, span_t'(COL_LIMIT), c1, c2);
      end else begin
        ok = remap_endpoint(it.first_scope, r1, c1, it.first_whole_row, it.first_whole_col);
        ok2 = remap_endpoint(it.second_scope, r2, c2, it.second_whole_row, it.second_whole_col);
        ok = ok && ok2;
      end
    end
    res = '0;
    if (ok) begin
      res.ref_valid = 1'b1;
      res.out_first_row = r1[ROW_W-1:0];
      res.out_first_col = c1[COL_W-1:0];
      res.out_second_row = r2[ROW_W-1:0];
      res.out_second_col = c2[COL_W-1:0];
    end
    return res;
  endfunction

  function automatic item_t make_item(input logic op, input logic [1:0] s1, input logic [1:0] s2,
                                      input logic same,
                                      input logic [ROW_W-1:0] r1, input logic [COL_W-1:0] c1,
                                      input logic wr1, input logic wc1,
                                      input logic [ROW_W-1:0] r2, input logic [COL_W-1:0] c2,
                                      input logic wr2, input logic wc2);
    item_t it;
    it.operation = op;
    it.first_scope = s1;
    it.second_scope = s2;
    it.same_sheet = same;
    it.first_row = r1;
    it.first_col = c1;
    it.first_whole_row = wr1;
    it.first_whole_col = wc1;
    it.second_row = r2;
    it.second_col = c2;
    it.second_whole_row = wr2;
    it.second_whole_col = wc2;
    return it;
  endfunction

  function automatic logic [ROW_W-1:0] pick_coord(input int unsigned mask);
    int unsigned v;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = mask;
      2: v = 0;
      3: v = 32'(edit_cfg.index) + $urandom_range(0, 16) - 8;
      4: v = 32'(edit_cfg.index) + 32'(edit_cfg.count) + $urandom_range(0, 16) - 8;
      default: v = $urandom_range(0, 63);
    endcase
    v = v & mask;
    return v[ROW_W-1:0];
  endfunction

  function automatic item_t random_item();
    item_t            it;
    logic [ROW_W-1:0] v;
    it.operation = 1'($urandom_range(0, 1));
    it.first_scope = 2'($urandom_range(0, 3));
    it.second_scope = 2'($urandom_range(0, 3));
    it.same_sheet = ($urandom_range(0, 3) != 0);
    it.first_row = pick_coord(ROW_MASK);
    v = pick_coord(COL_MASK);
    it.first_col = v[COL_W-1:0];
    it.first_whole_row = ($urandom_range(0, 5) == 0);
    it.first_whole_col = ($urandom_range(0, 5) == 0);
    it.second_row = pick_coord(ROW_MASK);
    v = pick_coord(COL_MASK);
    it.second_col = v[COL_W-1:0];
    it.second_whole_row = ($urandom_range(0, 5) == 0);
    it.second_whole_col = ($urandom_range(0, 5) == 0);
    return it;
  endfunction

  function automatic logic [REG_W-1:0] pick_span(input logic axis, input logic is_count);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return is_count ? 21'd1048576 : ((axis == AXIS_COL) ? 21'd16384 : 21'd1048576);
      2: return 21'h1F_FFFF;
      3: return REG_W'($urandom_range(0, 31));
      4: return REG_W'($urandom_range(0, (axis == AXIS_COL) ? 16383 : 1048575));
      default: return REG_W'(((axis == AXIS_COL) ? 16383 : 1048575) - $urandom_range(0, 15));
    endcase
  endfunction

  task automatic note_failure(input string what);
    if (failures < 10) $display("mismatch: %s", what);
    failures++;
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      note_failure($sformatf("result transfer with none expected: %h", got));
    end else begin
      want = expected_results.pop_front();
      if (got.ref_valid !== want.ref_valid)
        note_failure($sformatf("ref_valid expected %0h got %0h", want.ref_valid, got.ref_valid));
      if (got.out_first_row !== want.out_first_row)
        note_failure($sformatf("out_first_row expected %0h got %0h",
                               want.out_first_row, got.out_first_row));
      if (got.out_first_col !== want.out_first_col)
        note_failure($sformatf("out_first_col expected %0h got %0h",
                               want.out_first_col, got.out_first_col));
      if (got.out_second_row !== want.out_second_row)
        note_failure($sformatf("out_second_row expected %0h got %0h",
                               want.out_second_row, got.out_second_row));
      if (got.out_second_col !== want.out_second_col)
        note_failure($sformatf("out_second_col expected %0h got %0h",
                               want.out_second_col, got.out_second_col));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (result_valid) check_result(result);
      if (start && !busy) begin
        if (use_typed) expected_results.push_back(typed_result);
        else expected_results.push_back(predict_shift(item));
      end
      if (result_valid || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL row_col_reference_shift_unit");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic apply_cfg(input cfg_t c);
    write_reg(REG_AXIS, DATA_W'(c.axis));
    write_reg(REG_KIND, DATA_W'(c.kind));
    write_reg(REG_INDEX, DATA_W'(c.index));
    write_reg(REG_COUNT, DATA_W'(c.count));
    write_reg(REG_LOCAL, DATA_W'(c.local_is_target));
    edit_cfg = c;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic drive_item(input item_t it, input logic typed, input result_t want);
    start <= 1'b1;
    item <= it;
    use_typed <= typed;
    typed_result <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_row(input cfg_t c, input item_t it, input logic typed, input result_t want);
    directed_row_t row;
    row.cfg = c;
    row.stim = it;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  initial begin
    cfg_t  reset_cfg;
    cfg_t  row_ins;
    cfg_t  row_del;
    cfg_t  col_del_none;
    cfg_t  col_ins_top;
    cfg_t  col_del_all;
    cfg_t  row_ins_far;
    cfg_t  next_cfg;
    int    burst_left;

    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    use_typed = 1'b0;
    typed_result = '0;
    failures = 0;
    quiet_cycles = 0;
    edit_cfg = '0;

    reset_cfg = '0;
    row_ins = cfg_t'({AXIS_ROW, KIND_INSERT, 21'd10, 21'd5, 1'b1});
    row_del = cfg_t'({AXIS_ROW, KIND_DELETE, 21'd10, 21'd5, 1'b0});
    col_del_none = cfg_t'({AXIS_COL, KIND_DELETE, 21'd0, 21'd0, 1'b1});
    col_ins_top = cfg_t'({AXIS_COL, KIND_INSERT, 21'd16383, 21'd1, 1'b1});
    col_del_all = cfg_t'({AXIS_COL, KIND_DELETE, 21'd0, 21'h1F_FFFF, 1'b1});
    row_ins_far = cfg_t'({AXIS_ROW, KIND_INSERT, 21'd1048576, 21'd1048576, 1'b0});

    add_row(reset_cfg, make_item(OP_SINGLE, SCOPE_TARGET, SCOPE_LOCAL, 1'b0, 20'd5, 14'd7,
            1'b0, 1'b0, 20'd0, 14'd0, 1'b0, 1'b0), 1'b1,
            result_t'({1'b1, 20'd5, 14'd7, 20'd0, 14'd0}));
    add_row(reset_cfg, make_item(OP_SINGLE, SCOPE_LOCAL, SCOPE_LOCAL, 1'b0, 20'hF_FFFF,
            14'h3FFF, 1'b0, 1'b0, 20'd0, 14'd0, 1'b0, 1'b0), 1'b1,
            result_t'({1'b1, 20'hF_FFFF, 14'h3FFF, 20'd0, 14'd0}));
    add_row(row_ins, make_item(OP_SINGLE, SCOPE_LOCAL, SCOPE_LOCAL, 1'b0, 20'd10, 14'd3,
            1'b0, 1'b0, 20'd0, 14'd0, 1'b0, 1'b0), 1'b1,
            result_t'({1'b1, 20'd15, 14'd3, 20'd0, 14'd0}));
    add_row(row_ins, make_item(OP_SINGLE, SCOPE_TARGET, SCOPE_LOCAL, 1'b0, 20'd9, 14'd1,
            1'b0, 1'b0, 20'd0, 14'd0, 1'b0, 1'b0), 1'b0, INVALID_REF);
    add_row(row_ins, make_item(OP_SINGLE, SCOPE_TARGET, SCOPE_LOCAL, 1'b0, 20'hF_FFFF, 14'd1,
            1'b0, 1'b0, 20'd0, 14'd0, 1'b0, 1'b0), 1'b1, INVALID_REF);
    add_row(row_ins, make_item(OP_SINGLE, SCOPE_SPARE, SCOPE_LOCAL, 1'b0, 20'd20, 14'd4,
            1'b0, 1'b0, 20'd0, 14'd0, 1'b0, 1'b0), 1'b0, INVALID_REF);
    add_row(row_ins, make_item(OP_SINGLE, SCOPE_TARGET, SCOPE_LOCAL, 1'b0, 20'd20, 14'd4,
            1'b0, 1'b1, 20'd0, 14'd0, 1'b0, 1'b0), 1'b0, INVALID_REF);
    add_row(row_ins, make_item(OP_RANGE, SCOPE_TARGET, SCOPE_OTHER, 1'b0, 20'd12, 14'd2,
            1'b0, 1'b0, 20'd50, 14'd9, 1'b0, 1'b0), 1'b0, INVALID_REF);
    add_row(row_del, make_item(OP_SINGLE, SCOPE_TARGET, SCOPE_LOCAL, 1'b0, 20'd12, 14'd2,
            1'b0, 1'b0, 20'd0, 14'd0, 1'b0, 1'b0), 1'b1, INVALID_REF);
    add_row(row_del, make_item(OP_SINGLE, SCOPE_TARGET, SCOPE_LOCAL, 1'b0, 20'd20, 14'd2,
            1'b0, 1'b0, 20'd0, 14'd0, 1'b0, 1'b0), 1'b0, INVALID_REF);
    add_row(row_del, make_item(OP_RANGE, SCOPE_TARGET, SCOPE_TARGET, 1'b1, 20'd8, 14'd1,
            1'b0, 1'b0, 20'd20, 14'd6, 1'b0, 1'b0), 1'b0, INVALID_REF);
    add_row(row_del, make_item(OP_RANGE, SCOPE_TARGET, SCOPE_TARGET, 1'b1, 20'd20, 14'd1,
            1'b0, 1'b0, 20'd8, 14'd6, 1'b0, 1'b0), 1'b0, INVALID_REF);
    add_row(row_del, make_item(OP_RANGE, SCOPE_TARGET, SCOPE_TARGET, 1'b1, 20'd10, 14'd1,
            1'b0, 1'b0, 20'd14, 14'd6, 1'b0, 1'b0), 1'b1, INVALID_REF);
    add_row(row_del, make_item(OP_RANGE, SCOPE_TARGET, SCOPE_TARGET, 1'b0, 20'd8, 14'd1,
            1'b0, 1'b0, 20'd12, 14'd6, 1'b0, 1'b0), 1'b1, INVALID_REF);
    add_row(row_del, make_item(OP_RANGE, SCOPE_TARGET, SCOPE_TARGET, 1'b1, 20'd12, 14'd1,
            1'b0, 1'b1, 20'd13, 14'd6, 1'b0, 1'b1), 1'b0, INVALID_REF);
    add_row(row_del, make_item(OP_RANGE, SCOPE_TARGET, SCOPE_TARGET, 1'b1, 20'd12, 14'd1,
            1'b1, 1'b0, 20'd30, 14'd6, 1'b0, 1'b0), 1'b0, INVALID_REF);
    add_row(row_del, make_item(OP_RANGE, SCOPE_LOCAL, SCOPE_LOCAL, 1'b1, 20'd10, 14'd1,
            1'b0, 1'b0, 20'd14, 14'd6, 1'b0, 1'b0), 1'b0, INVALID_REF);
    add_row(col_del_none, make_item(OP_SINGLE, SCOPE_LOCAL, SCOPE_LOCAL, 1'b0, 20'd0,
            14'h3FFF, 1'b0, 1'b0, 20'd0, 14'd0, 1'b0, 1'b0), 1'b0, INVALID_REF);
    add_row(col_del_none, make_item(OP_RANGE, SCOPE_LOCAL, SCOPE_LOCAL, 1'b1, 20'd3, 14'd0,
            1'b0, 1'b0, 20'd4, 14'h3FFF, 1'b0, 1'b0), 1'b0, INVALID_REF);
    add_row(col_ins_top, make_item(OP_SINGLE, SCOPE_TARGET, SCOPE_LOCAL, 1'b0, 20'd7,
            14'h3FFF, 1'b0, 1'b0, 20'd0, 14'd0, 1'b0, 1'b0), 1'b1, INVALID_REF);
    add_row(col_ins_top, make_item(OP_SINGLE, SCOPE_TARGET, SCOPE_LOCAL, 1'b0, 20'd7,
            14'h3FFF, 1'b1, 1'b0, 20'd0, 14'd0, 1'b0, 1'b0), 1'b0, INVALID_REF);
    add_row(col_del_all, make_item(OP_SINGLE, SCOPE_LOCAL, SCOPE_LOCAL, 1'b0, 20'd7, 14'd0,
            1'b0, 1'b0, 20'd0, 14'd0, 1'b0, 1'b0), 1'b1, INVALID_REF);
    add_row(col_del_all, make_item(OP_RANGE, SCOPE_TARGET, SCOPE_OTHER, 1'b1, 20'hF_FFFF,
            14'd5, 1'b0, 1'b0, 20'hF_FFFF, 14'h3FFF, 1'b0, 1'b0), 1'b0, INVALID_REF);
    add_row(row_ins_far, make_item(OP_SINGLE, SCOPE_TARGET, SCOPE_LOCAL, 1'b0, 20'hF_FFFF,
            14'd9, 1'b0, 1'b0, 20'd0, 14'd0, 1'b0, 1'b0), 1'b0, INVALID_REF);
    add_row(row_ins_far, make_item(OP_RANGE, SCOPE_SPARE, SCOPE_LOCAL, 1'b1, 20'hF_FFFF,
            14'h3FFF, 1'b1, 1'b1, 20'hF_FFFF, 14'h3FFF, 1'b1, 1'b1), 1'b0, INVALID_REF);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < directed_rows.size(); i++) begin
      if (directed_rows[i].cfg !== edit_cfg) begin
        settle();
        apply_cfg(directed_rows[i].cfg);
      end
      drive_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      next_cfg.axis = (phase / 2) % 2 == 0 ? AXIS_ROW : AXIS_COL;
      next_cfg.kind = phase % 2 == 0 ? KIND_INSERT : KIND_DELETE;
      next_cfg.index = pick_span(next_cfg.axis, 1'b0);
      next_cfg.count = pick_span(next_cfg.axis, 1'b1);
      next_cfg.local_is_target = 1'($urandom_range(0, 1));
      apply_cfg(next_cfg);
      burst_left = $urandom_range(1, 40);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (burst_left == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 6)) @(negedge clk);
          burst_left = $urandom_range(1, 40);
        end
        drive_item(random_item(), 1'b0, INVALID_REF);
        burst_left--;
      end
    end

    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("PASS row_col_reference_shift_unit");
    end else begin
      $display("FAIL row_col_reference_shift_unit");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/rcrs_pkg.sv
rtl/rcrs_cfg.sv
rtl/rcrs_map.sv
rtl/row_col_reference_shift_unit.sv
verif/testbench.sv
